### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands for the RTL that checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFO_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RFO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### sv/rfo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring FIFO package
// Sizes, command codes and the transfer and control types of the ring FIFO.
// ----------------------------------------------------------------------------
package rfo_pkg;

   localparam int CAPACITY   = 15;
   localparam int DATA_WIDTH = 32;
   localparam int SLOTS      = CAPACITY + 1;
   localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CMD_W      = 2;
   localparam int OFFSET_W   = 4;
   localparam int FILL_W     = 4;

   localparam logic [CMD_W-1:0] CMD_PUT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_GET  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic [DATA_WIDTH-1:0] put_data;
      logic [OFFSET_W-1:0]   peek_offset;
   } req_type;

   typedef struct packed {
      logic                  ok;
      logic [DATA_WIDTH-1:0] read_data;
      logic [FILL_W-1:0]     fill_count;
      logic                  is_empty;
      logic                  is_full;
      logic                  peek_error;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic fetch;
      logic commit;
   } ctl_cmd_type;

endpackage

### sv/ring_fifo_with_overwrite_mode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring FIFO with overwrite mode
// A fifteen-entry word FIFO with put, get and peek requests.
// ----------------------------------------------------------------------------
// Requests enter on the req_ channel and each yields exactly one response
// transfer on the rsp_ channel, carrying status and any word read.
// The csr_ port sets the border policy: 0 refuses a put when full and a get
// when empty, 1 drops the oldest entry on a full put and returns zero on an
// empty get. Write it only while no request is in flight.
// A request is captured, its slot fetched and its result committed; a new
// request is taken only once the previous one is through the read of the
// single-port slot memory followed by the index and memory update.
// The response sits in an output register; the next request is taken
// while it waits. If the receiver stalls, that next request holds in its
// commit step until the pending response has been transferred.
// Reset empties the FIFO, selects the refusing policy and drops any
// pending response; slot contents are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ring_fifo_with_overwrite_mode (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic             csr_write_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  rfo_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rfo_pkg::rsp_type rsp_data
);
   import rfo_pkg::*;

   ctl_cmd_type ctl_cmd;

   rfo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl_cmd   (ctl_cmd)
   );

   rfo_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl_cmd          (ctl_cmd),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .rsp_data         (rsp_data)
   );

   `RFO_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)
   `RFO_ASSERT_NEXT(a_commit_shows, clock, reset, ctl_cmd.commit, rsp_valid)
   `RFO_ASSERT_NOW(a_empty_status, clock, reset, rsp_valid && rsp_data.is_empty, rsp_data.fill_count == '0 && !rsp_data.is_full)
   `RFO_ASSERT_NOW(a_peek_flag, clock, reset, rsp_valid && rsp_data.peek_error, !rsp_data.ok && rsp_data.read_data == '0)

endmodule

### sv/rfo_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring FIFO controller
// Sequences capture, slot fetch and commit of one request at a time.
// ----------------------------------------------------------------------------
module rfo_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rfo_pkg::ctl_cmd_type ctl_cmd
);
   import rfo_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      commit_ok;

   assign req_ready = (state_ff == ST_IDLE);
   assign commit_ok = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit_ok) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign ctl_cmd.capture = req_valid && req_ready;
   assign ctl_cmd.fetch   = (state_ff == ST_FETCH);
   assign ctl_cmd.commit  = commit_ok;

endmodule

### sv/rfo_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring FIFO datapath
// Slot memory, ring indices, mode register and the result register.
// ----------------------------------------------------------------------------
module rfo_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  rfo_pkg::ctl_cmd_type ctl_cmd,
   input  logic                 csr_write_enable,
   input  logic                 csr_write_data,
   input  rfo_pkg::req_type     req_data,
   output rfo_pkg::rsp_type     rsp_data
);
   import rfo_pkg::*;

   localparam int SUM_W = ((IDX_W > OFFSET_W) ? IDX_W : OFFSET_W) + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [IDX_W:0]   SLOTS_X  = (IDX_W + 1)'(SLOTS);
   localparam logic [SUM_W-1:0] SLOTS_S  = SUM_W'(SLOTS);

   function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] idx);
      inc_idx = (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] fill_of(input logic [IDX_W-1:0] wr,
                                                input logic [IDX_W-1:0] rd);
      logic [IDX_W:0] diff;
      diff = (wr >= rd) ? ({1'b0, wr} - {1'b0, rd}) : ({1'b0, wr} + SLOTS_X - {1'b0, rd});
      fill_of = diff[IDX_W-1:0];
   endfunction

   logic [DATA_WIDTH-1:0] slot_mem_ff [SLOTS];
   req_type               req_ff;
   req_type               req_in;
   logic                  mode_ff;
   logic                  mode_in;
   logic [IDX_W-1:0]      wr_idx_ff;
   logic [IDX_W-1:0]      wr_idx_in;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic [IDX_W-1:0]      rd_idx_in;
   logic [DATA_WIDTH-1:0] mem_q_ff;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   logic                  is_empty;
   logic                  is_full;
   logic [IDX_W-1:0]      fill_now;
   logic [IDX_W-1:0]      fill_next;
   logic [SUM_W-1:0]      peek_sum;
   logic [IDX_W-1:0]      peek_addr;
   logic [IDX_W-1:0]      fetch_addr;
   logic                  peek_hit;
   logic                  mem_we;
   logic                  ok;
   logic                  peek_err;
   logic [DATA_WIDTH-1:0] rdata;

   assign req_in  = ctl_cmd.capture ? req_data : req_ff;
   assign mode_in = csr_write_enable ? csr_write_data : mode_ff;

   assign is_empty = (wr_idx_ff == rd_idx_ff);
   assign is_full  = (inc_idx(wr_idx_ff) == rd_idx_ff);
   assign fill_now = fill_of(wr_idx_ff, rd_idx_ff);
   assign peek_hit = SUM_W'(req_ff.peek_offset) < SUM_W'(fill_now);

   assign peek_sum   = SUM_W'(rd_idx_ff) + SUM_W'(req_ff.peek_offset);
   assign peek_addr  = (peek_sum >= SLOTS_S) ? IDX_W'(peek_sum - SLOTS_S) : IDX_W'(peek_sum);
   assign fetch_addr = (req_ff.cmd == CMD_PEEK) ? peek_addr : rd_idx_ff;

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      mem_we    = 1'b0;
      ok        = 1'b0;
      peek_err  = 1'b0;
      rdata     = '0;
      case (req_ff.cmd)
         CMD_PUT: begin
            if (is_full && mode_ff) begin
               rd_idx_in = inc_idx(rd_idx_ff);
            end
            if (!is_full || mode_ff) begin
               mem_we    = 1'b1;
               wr_idx_in = inc_idx(wr_idx_ff);
               ok        = 1'b1;
            end
         end
         CMD_GET: begin
            if (!is_empty) begin
               rdata     = mem_q_ff;
               rd_idx_in = inc_idx(rd_idx_ff);
               ok        = 1'b1;
            end else if (mode_ff) begin
               wr_idx_in = inc_idx(wr_idx_ff);
               rd_idx_in = inc_idx(rd_idx_ff);
               ok        = 1'b1;
            end
         end
         CMD_PEEK: begin
            if (peek_hit) begin
               rdata = mem_q_ff;
               ok    = 1'b1;
            end else begin
               peek_err = 1'b1;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   assign fill_next = fill_of(wr_idx_in, rd_idx_in);

   always_comb begin
      rsp_in            = rsp_ff;
      if (ctl_cmd.commit) begin
         rsp_in.ok         = ok;
         rsp_in.read_data  = rdata;
         rsp_in.fill_count = FILL_W'(fill_next);
         rsp_in.is_empty   = (wr_idx_in == rd_idx_in);
         rsp_in.is_full    = (inc_idx(wr_idx_in) == rd_idx_in);
         rsp_in.peek_error = peek_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         if (ctl_cmd.commit) begin
            wr_idx_ff <= wr_idx_in;
            rd_idx_ff <= rd_idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.fetch) begin
         mem_q_ff <= slot_mem_ff[fetch_addr];
      end
      if (ctl_cmd.commit && mem_we) begin
         slot_mem_ff[wr_idx_ff] <= req_ff.put_data;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring FIFO testbench
// Runs put, get and peek requests through the ring FIFO under both border
// policies, with random gaps and stalls on both channels and one long stall
// of the receiver. A scoreboard mirrors the slots and indices, predicts the
// response of every accepted request and compares every response field.
// ----------------------------------------------------------------------------
module tb_top;
   import rfo_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int HOLD_CYCLES    = 100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 120;

   class fifo_scoreboard;
      logic [DATA_WIDTH-1:0] slots [SLOTS];
      int unsigned           wr_idx;
      int unsigned           rd_idx;
      logic                  overwrite;
      rsp_type               owed[$];
      int                    mismatches;
      int                    checked;
      int                    puts, gets, peeks, unused_cmds;
      int                    overwrites, refusals, peek_errors, empty_fills;

      function new();
         wr_idx = 0;
         rd_idx = 0;
         overwrite = 1'b0;
      endfunction

      function int unsigned fill();
         return (wr_idx + SLOTS - rd_idx) % SLOTS;
      endfunction

      function bit full();
         return ((wr_idx + 1) % SLOTS) == rd_idx;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         e = '0;
         case (r.cmd)
            CMD_PUT: begin
               puts++;
               if (full() && overwrite) begin
                  rd_idx = (rd_idx + 1) % SLOTS;
                  overwrites++;
               end
               if (!full()) begin
                  slots[wr_idx] = r.put_data;
                  wr_idx = (wr_idx + 1) % SLOTS;
                  e.ok = 1'b1;
               end else begin
                  refusals++;
               end
            end
            CMD_GET: begin
               gets++;
               if (wr_idx == rd_idx && overwrite) begin
                  slots[wr_idx] = '0;
                  wr_idx = (wr_idx + 1) % SLOTS;
                  empty_fills++;
               end
               if (wr_idx != rd_idx) begin
                  e.read_data = slots[rd_idx];
                  rd_idx = (rd_idx + 1) % SLOTS;
                  e.ok = 1'b1;
               end else begin
                  refusals++;
               end
            end
            CMD_PEEK: begin
               peeks++;
               if (r.peek_offset < fill()) begin
                  e.read_data = slots[(rd_idx + r.peek_offset) % SLOTS];
                  e.ok = 1'b1;
               end else begin
                  e.peek_error = 1'b1;
                  peek_errors++;
               end
            end
            default: begin
               unused_cmds++;
            end
         endcase
         e.fill_count = FILL_W'(fill());
         e.is_empty = (wr_idx == rd_idx);
         e.is_full = full();
         owed.push_back(e);
      endfunction

      task report_mismatch(string field, longint unsigned got_v, longint unsigned exp_v);
         mismatches++;
         $display("%0t: MISMATCH %s: got %0h, expected %0h", $realtime, field, got_v, exp_v);
      endtask

      task check_response(rsp_type got);
         rsp_type e;
         if (owed.size() == 0) begin
            report_mismatch("response with no request outstanding", got, 0);
            return;
         end
         e = owed.pop_front();
         checked++;
         if (got.ok !== e.ok) report_mismatch("ok", got.ok, e.ok);
         if (got.read_data !== e.read_data)
            report_mismatch("read_data", got.read_data, e.read_data);
         if (got.fill_count !== e.fill_count)
            report_mismatch("fill_count", got.fill_count, e.fill_count);
         if (got.is_empty !== e.is_empty) report_mismatch("is_empty", got.is_empty, e.is_empty);
         if (got.is_full !== e.is_full) report_mismatch("is_full", got.is_full, e.is_full);
         if (got.peek_error !== e.peek_error)
            report_mismatch("peek_error", got.peek_error, e.peek_error);
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    csr_write_enable;
   logic    csr_write_data;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   fifo_scoreboard sb = new();
   int  idle_pct;
   bit  hold_off;
   int  quiet_cycles;

   ring_fifo_with_overwrite_mode dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : receiver
      int n;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off = 1'b0;
            rsp_ready = 1'b1;
         end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_ready = 1'b0;
            n = $urandom_range(1, 16);
            repeat (n) @(negedge clock);
            rsp_ready = 1'b1;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   function automatic req_type make_item(logic [CMD_W-1:0] cmd, logic [DATA_WIDTH-1:0] data,
                                         logic [OFFSET_W-1:0] offset);
      req_type r;
      r.cmd = cmd;
      r.put_data = data;
      r.peek_offset = offset;
      return r;
   endfunction

   function automatic req_type random_item(int bias);
      int roll;
      logic [CMD_W-1:0] cmd;
      logic [DATA_WIDTH-1:0] data;
      int put_lim, get_lim;
      case (bias)
         1:       begin put_lim = 70; get_lim = 85; end
         2:       begin put_lim = 20; get_lim = 75; end
         3:       begin put_lim = 30; get_lim = 50; end
         default: begin put_lim = 40; get_lim = 75; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < put_lim) cmd = CMD_PUT;
      else if (roll < get_lim) cmd = CMD_GET;
      else if (roll < 97) cmd = CMD_PEEK;
      else cmd = CMD_UNUSED;
      case ($urandom_range(0, 15))
         0:       data = '0;
         1:       data = '1;
         default: data = $urandom;
      endcase
      return make_item(cmd, data, OFFSET_W'($urandom_range(0, 15)));
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(req_type r);
      int gap;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid = 1'b0;
         gap = $urandom_range(1, 16);
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (sb.owed.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_policy(logic mode);
      wait_drained();
      csr_write_enable = 1'b1;
      csr_write_data = mode;
      sb.overwrite = mode;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   initial begin : stimulus
      int idle_plan [11] = '{20, 0, 10, 30, 5, 20, 0, 15, 25, 10, 0};
      logic [DATA_WIDTH-1:0] words [6] = '{32'h0, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                                           32'h5555_5555, 32'h8000_0000, 32'h0000_0001};
      int n;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      req_valid = 1'b0;
      req_data = '0;
      idle_pct = 0;
      hold_off = 1'b0;
      quiet_cycles = 0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      set_policy(1'b0);
      send_item(make_item(CMD_GET, '0, '0));
      send_item(make_item(CMD_PEEK, '0, '0));
      send_item(make_item(CMD_PEEK, '0, 4'd15));
      send_item(make_item(CMD_UNUSED, '1, '1));
      for (int i = 0; i < CAPACITY; i++)
         send_item(make_item(CMD_PUT, (i < 6) ? words[i] : $urandom, '0));
      send_item(make_item(CMD_PUT, 32'hDEAD_BEEF, '0));
      send_item(make_item(CMD_PEEK, '0, 4'd14));
      send_item(make_item(CMD_PEEK, '0, 4'd15));
      send_item(make_item(CMD_UNUSED, '0, '0));
      req_valid = 1'b0;

      set_policy(1'b1);
      send_item(make_item(CMD_PUT, 32'h1234_5678, '0));
      send_item(make_item(CMD_PEEK, '0, '0));
      req_valid = 1'b0;

      for (int p = 0; p < 11; p++) begin
         set_policy(p[0]);
         idle_pct = idle_plan[p];
         if (p == 2) hold_off = 1'b1;
         n = (p == 10) ? 40 : PHASE_ITEMS;
         for (int i = 0; i < n; i++)
            send_item(random_item((p == 2) ? 1 : p % 4));
         req_valid = 1'b0;
      end

      wait_drained();
      repeat (8) @(negedge clock);
      $display("Covered %0d requests: %0d puts, %0d gets, %0d peeks, %0d unused codes.",
               sb.puts + sb.gets + sb.peeks + sb.unused_cmds, sb.puts, sb.gets, sb.peeks,
               sb.unused_cmds);
      $display("Both policies: %0d overwrites, %0d zero fills, %0d refusals, %0d peek errors.",
               sb.overwrites, sb.empty_fills, sb.refusals, sb.peek_errors);
      if (sb.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule

### filelist.f
+incdir+sv
sv/rfo_pkg.sv
sv/rfo_ctrl.sv
sv/rfo_datapath.sv
sv/ring_fifo_with_overwrite_mode.sv
tb/tb_top.sv
